// File: rtl/core/stereo_tremolo_sine_lfo_defines.svh
// Assertion macros shared by the tremolo RTL.
`ifndef STEREO_TREMOLO_SINE_LFO_DEFINES_SVH
`define STEREO_TREMOLO_SINE_LFO_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Concurrent assertion that is switched off while reset is asserted.
`define STT_ASSERT_RST(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
// Concurrent assertion that is checked at every rising clock edge.
`define STT_ASSERT(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define STT_ASSERT_RST(lbl, clk_s, rst_s, prop, msg)
`define STT_ASSERT(lbl, clk_s, prop, msg)
`endif

`endif

// File: rtl/core/sttrem_pkg.sv
package sttrem_pkg;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 24;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_STEP  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEPTH       = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STEREO_MODE = 2'd2;

  // Register reset values.
  localparam logic [23:0] PHASE_STEP_RESET = 24'd357914;
  localparam logic [15:0] DEPTH_RESET      = 16'd16384;

  // Unity in Q1.15 and pi/2 in Q30 for building the sine table.
  localparam logic [16:0] ONE_Q15     = 17'd32768;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_ROM,
    S_GAIN,
    S_GL,
    S_ML,
    S_MR,
    S_FIN
  } state_t;

endpackage

// File: rtl/core/sttrem_if.sv
// Input sample channel.
interface sttrem_in_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] left_in;
  logic signed [W-1:0] right_in;
  modport source (output valid, output left_in, output right_in, input ready);
  modport sink (input valid, input left_in, input right_in, output ready);
endinterface

// Result sample channel.
interface sttrem_out_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] left_out;
  logic signed [W-1:0] right_out;
  modport source (output valid, output left_out, output right_out, input ready);
  modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// Configuration write channel.
interface sttrem_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [sttrem_pkg::CFG_INDEX_BITS-1:0] index;
  logic [sttrem_pkg::CFG_DATA_BITS-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/stereo_tremolo_sine_lfo.sv
// Channel   Modport  Payload                        Accepted when
// in_s      sink     left_in, right_in (signed)     in_s.valid && in_s.ready
// out_s     source   left_out, right_out (signed)   out_s.valid && out_s.ready
// cfg_s     sink     index, data                    cfg_s.valid && cfg_s.ready
//
// An item passes the steps S_ROM to S_FIN before the next is accepted: a registered
// sine ROM read and three passes through the single shared multiplier
// (depth times sine, then left and right sample times gain), each registered.
// The result register lets the next item be accepted while a result waits.
// A stalled result holds the sequencer in its last step until the slot frees.
// Reset is synchronous (rst_n low) and needs no clearing pass; the sine table
// is a constant.
`include "stereo_tremolo_sine_lfo_defines.svh"

module stereo_tremolo_sine_lfo #(
  parameter int SAMPLE_BITS        = 16,
  parameter int PHASE_BITS         = 32,
  parameter int SINE_TABLE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  sttrem_in_if.sink   in_s,
  sttrem_out_if.source out_s,
  sttrem_cfg_if.sink  cfg_s
);

  localparam int LB = PHASE_BITS - 2;
  localparam int IW = $clog2(SINE_TABLE_ENTRIES);
  localparam int NB = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int AW = (SAMPLE_BITS > 18) ? SAMPLE_BITS : 18;
  localparam int PW = AW + 18;
  localparam logic signed [PW-1:0] SAT_HI =
    {{(PW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [PW-1:0] SAT_LO = ~SAT_HI;

  // Sine entry by an integer Taylor series in Q30, rounded to Q15.
  function automatic logic [15:0] sine_q15(input int unsigned idx);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        r;
    logic signed [63:0] sum;
    x    = (64'(idx) * sttrem_pkg::HALF_PI_Q30) / SINE_TABLE_ENTRIES;
    x2   = (x * x) >> 30;
    term = x;
    sum  = '0;
    for (int k = 0; k < 7; k++) begin
      if ((k & 1) != 0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
      term = (term * x2) >> 30;
      case (k)
        0: term = term / 6;
        1: term = term / 20;
        2: term = term / 42;
        3: term = term / 72;
        4: term = term / 110;
        5: term = term / 156;
        default: term = term / 210;
      endcase
    end
    if (sum < 0) begin
      sum = '0;
    end
    r = (unsigned'(sum) + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return 16'(r);
  endfunction

  // Floor shift by 15 and saturate to the sample width.
  function automatic logic [SAMPLE_BITS-1:0] sat_shift(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] sh;
    sh = v >>> 15;
    if (sh > SAT_HI) begin
      sh = SAT_HI;
    end else if (sh < SAT_LO) begin
      sh = SAT_LO;
    end
    return sh[SAMPLE_BITS-1:0];
  endfunction

  // Quarter-wave sine table.
  logic [15:0] sine_rom [SINE_TABLE_ENTRIES];
  for (genvar gi = 0; gi < SINE_TABLE_ENTRIES; gi++) begin : g_rom
    assign sine_rom[gi] = sine_q15(gi);
  end

  sttrem_pkg::state_t state_r, state_nxt;

  logic [23:0]           phase_step_r;
  logic [15:0]           depth_r;
  logic                  stereo_mode_r;
  logic [PHASE_BITS-1:0] phase_r;

  logic signed [SAMPLE_BITS-1:0] x_l_r, x_r_r;
  logic [1:0]                    q_r;
  logic [IW-1:0]                 p_r;
  logic [15:0]                   rom_q_r;
  logic                          neg_r;
  logic                          max_r;
  logic signed [PW-1:0]          prod_r;
  logic signed [17:0]            gl_r, gr_r;
  logic [SAMPLE_BITS-1:0]        left_sat_r;
  logic                          out_valid_r;
  logic [SAMPLE_BITS-1:0]        out_left_r, out_right_r;

  logic                  in_ready;
  logic                  in_fire;
  logic                  out_load;
  logic [PHASE_BITS-1:0] step_ext;
  logic [LB+NB-1:0]      pfull;
  logic [IW-1:0]         rom_addr;
  logic [16:0]           d_sat;
  logic signed [17:0]    one_minus_d;
  logic [16:0]           sine_mag;
  logic signed [17:0]    sine_s;
  logic signed [AW-1:0]  mul_a;
  logic signed [17:0]    mul_b;
  logic signed [PW-1:0]  prod_shift;

  // Phase step, truncated or widened to the accumulator width.
  assign step_ext = PHASE_BITS'({{PHASE_BITS{1'b0}}, phase_step_r});

  // Table position from the bits below the quadrant.
  assign pfull = (LB + NB)'(phase_r[LB-1:0]) * (LB + NB)'(SINE_TABLE_ENTRIES);

  // Odd quadrants read the table backward; position zero there is full scale.
  always_comb begin
    if (q_r[0] && (p_r == '0)) begin
      rom_addr = '0;
    end else if (q_r[0]) begin
      rom_addr = IW'(SINE_TABLE_ENTRIES) - p_r;
    end else begin
      rom_addr = p_r;
    end
  end

  // Depth saturates at full scale.
  assign d_sat       = (depth_r > 16'd32768) ? sttrem_pkg::ONE_Q15 : {1'b0, depth_r};
  assign one_minus_d = signed'({1'b0, sttrem_pkg::ONE_Q15 - d_sat});

  // Signed sine sample from the table read.
  assign sine_mag = max_r ? 17'd32767 : {1'b0, rom_q_r};
  assign sine_s   = neg_r ? -signed'({1'b0, sine_mag}) : signed'({1'b0, sine_mag});

  assign prod_shift = prod_r >>> 15;
  assign in_fire    = in_s.valid && in_ready;

  // Sequencer: next state, handshake and multiplier operand selection.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    mul_a     = AW'(x_l_r);
    mul_b     = gl_r;
    case (state_r)
      sttrem_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_s.valid) begin
          state_nxt = sttrem_pkg::S_ROM;
        end
      end
      sttrem_pkg::S_ROM: begin
        state_nxt = sttrem_pkg::S_GAIN;
      end
      sttrem_pkg::S_GAIN: begin
        mul_a     = AW'(signed'({1'b0, d_sat}));
        mul_b     = sine_s;
        state_nxt = sttrem_pkg::S_GL;
      end
      sttrem_pkg::S_GL: begin
        state_nxt = sttrem_pkg::S_ML;
      end
      sttrem_pkg::S_ML: begin
        mul_a     = AW'(x_l_r);
        mul_b     = gl_r;
        state_nxt = sttrem_pkg::S_MR;
      end
      sttrem_pkg::S_MR: begin
        mul_a     = AW'(x_r_r);
        mul_b     = gr_r;
        state_nxt = sttrem_pkg::S_FIN;
      end
      sttrem_pkg::S_FIN: begin
        out_load = !out_valid_r || out_s.ready;
        if (out_load) begin
          state_nxt = sttrem_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sttrem_pkg::S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sttrem_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers and phase accumulator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r  <= sttrem_pkg::PHASE_STEP_RESET;
      depth_r       <= sttrem_pkg::DEPTH_RESET;
      stereo_mode_r <= 1'b0;
      phase_r       <= '0;
    end else begin
      if (cfg_s.valid) begin
        case (cfg_s.index)
          sttrem_pkg::CFG_PHASE_STEP:  phase_step_r  <= cfg_s.data;
          sttrem_pkg::CFG_DEPTH:       depth_r       <= cfg_s.data[15:0];
          sttrem_pkg::CFG_STEREO_MODE: stereo_mode_r <= cfg_s.data[0];
          default: ;
        endcase
      end
      if (in_fire) begin
        phase_r <= phase_r + step_ext;
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_s.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Datapath registers, loaded step by step.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_l_r <= in_s.left_in;
      x_r_r <= in_s.right_in;
      q_r   <= phase_r[PHASE_BITS-1:PHASE_BITS-2];
      p_r   <= pfull[LB+IW-1:LB];
    end
    if (state_r == sttrem_pkg::S_ROM) begin
      rom_q_r <= sine_rom[rom_addr];
      neg_r   <= q_r[1];
      max_r   <= q_r[0] && (p_r == '0);
    end
    if ((state_r == sttrem_pkg::S_GAIN) || (state_r == sttrem_pkg::S_ML) ||
        (state_r == sttrem_pkg::S_MR)) begin
      prod_r <= PW'(mul_a) * PW'(mul_b);
    end
    if (state_r == sttrem_pkg::S_GL) begin
      gl_r <= signed'(prod_shift[17:0]) + one_minus_d;
    end
    if (state_r == sttrem_pkg::S_ML) begin
      gr_r <= stereo_mode_r ? ((one_minus_d <<< 1) - gl_r) : gl_r;
    end
    if (state_r == sttrem_pkg::S_MR) begin
      left_sat_r <= sat_shift(prod_r);
    end
    if (out_load) begin
      out_left_r  <= left_sat_r;
      out_right_r <= sat_shift(prod_r);
    end
  end

  assign in_s.ready      = in_ready;
  assign cfg_s.ready     = 1'b1;
  assign out_s.valid     = out_valid_r;
  assign out_s.left_out  = out_left_r;
  assign out_s.right_out = out_right_r;

  // Accepting an item advances the phase by exactly one step.
  `STT_ASSERT_RST(a_phase_adv, clk, rst_n,
                  in_fire |=> (phase_r == $past(phase_r + step_ext)),
                  "phase did not advance by one step")
  // The right-lane product is always followed by the delivery step.
  `STT_ASSERT_RST(a_mr_to_fin, clk, rst_n,
                  (state_r == sttrem_pkg::S_MR) |=> (state_r == sttrem_pkg::S_FIN),
                  "sequencer skipped delivery")
  // A pending result that is not taken holds the sequencer in delivery.
  `STT_ASSERT_RST(a_fin_hold, clk, rst_n,
                  ((state_r == sttrem_pkg::S_FIN) && out_valid_r && !out_s.ready) |=>
                  (state_r == sttrem_pkg::S_FIN),
                  "result overwritten while stalled")
  // The left gain stays within plus and minus unity.
  `STT_ASSERT_RST(a_gain_range, clk, rst_n,
                  (state_r == sttrem_pkg::S_ML) |->
                  ((gl_r <= 18'sd32768) && (gl_r >= -18'sd32768)),
                  "left gain out of range")

endmodule
